>>> rtl/core/krt_pkg.sv
package krt_pkg;

   // Cap on the results of one list-by-channel transaction
   localparam int MAX_RESULTS = 16;
   localparam int HIT_W       = $clog2(MAX_RESULTS);

   typedef enum logic [1:0] {
      ACT_SAVE     = 2'd0,
      ACT_FIND_ID  = 2'd1,
      ACT_FIND_SYM = 2'd2,
      ACT_LIST     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_CONFLICT  = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] id;
      logic [63:0] symbol;
      logic [15:0] channel;
   } rec_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] rec_id;
      logic [63:0] rec_symbol;
      logic [15:0] rec_channel;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] out_id;
      logic [63:0] out_symbol;
      logic [15:0] out_channel;
      logic        last;
   } rsp_type;

   // Compare unit result for one table entry
   typedef struct packed {
      logic id_eq;
      logic hit;
   } match_type;

   function automatic rsp_type make_rsp(status_type st, rec_type r, logic fin);
      rsp_type res;
      res.status      = st;
      res.out_id      = r.id;
      res.out_symbol  = r.symbol;
      res.out_channel = r.channel;
      res.last        = fin;
      return res;
   endfunction

endpackage

>>> rtl/core/krt_store.sv
module krt_store #(
   parameter int TABLE_SLOTS  = 16,
   parameter int SYMBOL_BYTES = 8
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
   input  krt_pkg::rec_type               wr_rec,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
   output krt_pkg::rec_type               rd_rec
);
   import krt_pkg::*;

   localparam int SW = 8 * SYMBOL_BYTES;
   localparam int EW = 32 + SW + 16;

   // Only the kept symbol bytes are stored
   logic [EW-1:0] mem [TABLE_SLOTS];
   logic [EW-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_rec.id, wr_rec.symbol[SW-1:0], wr_rec.channel};
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_rec.id      = rd_word_ff[EW-1 -: 32];
   assign rd_rec.symbol  = 64'(rd_word_ff[16 +: SW]);
   assign rd_rec.channel = rd_word_ff[15:0];

endmodule

>>> rtl/core/krt_match.sv
module krt_match (
   input  krt_pkg::action_type action,
   input  krt_pkg::rec_type    key,
   input  krt_pkg::rec_type    entry,
   output krt_pkg::match_type  result
);
   import krt_pkg::*;

   logic id_eq;
   logic sym_eq;
   logic chan_eq;

   assign id_eq   = (key.id == entry.id);
   assign sym_eq  = (key.symbol == entry.symbol);
   assign chan_eq = (key.channel == entry.channel);

   always_comb begin
      result.id_eq = id_eq;
      unique case (action)
         ACT_SAVE:     result.hit = sym_eq && !id_eq;  // symbol owned by another id
         ACT_FIND_ID:  result.hit = id_eq;
         ACT_FIND_SYM: result.hit = sym_eq;
         ACT_LIST:     result.hit = chan_eq;
         default:      result.hit = 1'b0;
      endcase
   end

endmodule

>>> rtl/core/keyed_record_table_core.sv
// Keyed record table: up to TABLE_SLOTS records of {id, symbol, channel}. A request
// transaction is a save, a find by id, a find by symbol, or a list of every record
// on a channel. Each request walks the occupied slots once through the single read
// port of the record store, one slot per cycle, feeding one shared compare unit; an
// empty table skips the walk, and req_stall stays high until the request's final
// response has been loaded into the output register. List responses stall the walk
// while rsp_stall holds the output register. Records are never removed, so occupied
// slots are always 0..N-1, N being the number of records held, and a fill count
// replaces per-slot valid bits; no clearing pass runs after reset. Every request
// yields at least one response transaction and the final one carries last = 1; a
// list returns at most 16 records, lowest slots first.
module keyed_record_table_core #(
   parameter int TABLE_SLOTS  = 16,
   parameter int SYMBOL_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  krt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output krt_pkg::rsp_type rsp_data
);
   import krt_pkg::*;

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int NW = $clog2(TABLE_SLOTS + 1);
   localparam int SW = 8 * SYMBOL_BYTES;
   localparam logic [63:0] SYM_MASK = {64{1'b1}} >> (64 - SW);

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'b001,
      SEQ_SCAN = 3'b010,
      SEQ_DONE = 3'b100
   } seq_type;

   // Control state
   seq_type          state_ff, state_in;
   logic [NW-1:0]    cnt_ff, cnt_in;       // records held
   logic [NW-1:0]    a_ff, a_in;           // next slot to read
   logic [AW-1:0]    d_ff, d_in;           // slot whose data sits in the read register
   logic             dv_ff, dv_in;         // read register holds live data
   logic             idf_ff, idf_in;       // save: id already stored
   logic [AW-1:0]    ids_ff, ids_in;       // save: slot of that id
   logic             hf_ff, hf_in;         // hit record held
   logic [HIT_W-1:0] nhit_ff, nhit_in;     // list hits taken so far
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload
   action_type act_ff, act_in;
   rec_type    key_ff, key_in;
   rec_type    hrec_ff, hrec_in;           // first hit, conflict owner, or pending list hit
   rsp_type    rsp_data_ff, rsp_data_in;

   logic          rd_en;
   rec_type       rd_rec;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   match_type     mres;

   logic    issue;
   logic    hold;
   logic    out_free;
   logic    load;
   rsp_type load_data;

   krt_store #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .SYMBOL_BYTES(SYMBOL_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_rec (key_ff),
      .rd_en  (rd_en),
      .rd_addr(a_ff[AW-1:0]),
      .rd_rec (rd_rec)
   );

   krt_match u_match (
      .action(act_ff),
      .key   (key_ff),
      .entry (rd_rec),
      .result(mres)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = (a_ff < cnt_ff);
   // A new list hit must push the pending one out; wait if the output is busy
   assign hold      = dv_ff && (act_ff == ACT_LIST) && mres.hit && hf_ff && !out_free;
   assign req_stall = (state_ff != SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      a_in      = a_ff;
      d_in      = d_ff;
      dv_in     = dv_ff;
      idf_in    = idf_ff;
      ids_in    = ids_ff;
      hf_in     = hf_ff;
      nhit_in   = nhit_ff;
      act_in    = act_ff;
      key_in    = key_ff;
      hrec_in   = hrec_ff;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = ids_ff;
      load      = 1'b0;
      load_data = '0;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               act_in         = req_data.action;
               key_in.id      = req_data.rec_id;
               key_in.symbol  = req_data.rec_symbol & SYM_MASK;
               key_in.channel = req_data.rec_channel;
               a_in           = '0;
               dv_in          = 1'b0;
               idf_in         = 1'b0;
               hf_in          = 1'b0;
               nhit_in        = '0;
               state_in       = (cnt_ff == '0) ? SEQ_DONE : SEQ_SCAN;
            end
         end

         SEQ_SCAN: begin
            if (!hold) begin
               rd_en = issue;
               a_in  = a_ff + NW'(issue);
               d_in  = a_ff[AW-1:0];
               dv_in = issue;
               if (dv_ff) begin
                  if (act_ff == ACT_SAVE && mres.id_eq && !idf_ff) begin
                     idf_in = 1'b1;
                     ids_in = d_ff;
                  end
                  if (mres.hit) begin
                     if (act_ff == ACT_LIST) begin
                        if (hf_ff) begin
                           load      = 1'b1;
                           load_data = make_rsp(STAT_OK, hrec_ff, 1'b0);
                        end
                        hf_in   = 1'b1;
                        hrec_in = rd_rec;
                        nhit_in = nhit_ff + HIT_W'(1);
                        if (nhit_ff == HIT_W'(MAX_RESULTS - 1)) begin
                           state_in = SEQ_DONE;   // result cap reached
                        end
                     end else if (!hf_ff) begin
                        hf_in   = 1'b1;
                        hrec_in = rd_rec;
                     end
                  end
                  if (!issue) begin
                     state_in = SEQ_DONE;
                  end
               end
            end
         end

         SEQ_DONE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = SEQ_IDLE;
               if (act_ff == ACT_SAVE) begin
                  priority if (idf_ff && hf_ff) begin
                     load_data = make_rsp(STAT_CONFLICT, hrec_ff, 1'b1);
                  end else if (idf_ff) begin
                     wr_en     = 1'b1;
                     wr_addr   = ids_ff;
                     load_data = make_rsp(STAT_OK, key_ff, 1'b1);
                  end else if (cnt_ff == NW'(TABLE_SLOTS)) begin
                     load_data = make_rsp(STAT_FULL, '0, 1'b1);
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = cnt_ff[AW-1:0];
                     cnt_in    = cnt_ff + NW'(1);
                     load_data = make_rsp(STAT_OK, key_ff, 1'b1);
                  end
               end else if (hf_ff) begin
                  load_data = make_rsp(STAT_OK, hrec_ff, 1'b1);
               end else begin
                  load_data = make_rsp(STAT_NOT_FOUND, '0, 1'b1);
               end
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      // Output register
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cnt_ff       <= '0;
         a_ff         <= '0;
         dv_ff        <= 1'b0;
         idf_ff       <= 1'b0;
         hf_ff        <= 1'b0;
         nhit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         a_ff         <= a_in;
         dv_ff        <= dv_in;
         idf_ff       <= idf_in;
         hf_ff        <= hf_in;
         nhit_ff      <= nhit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      ids_ff      <= ids_in;
      act_ff      <= act_in;
      key_ff      <= key_in;
      hrec_ff     <= hrec_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Fill count never passes the table size
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(TABLE_SLOTS))
      else $error("record count beyond table size");

   // Only occupied slots are ever examined
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> (NW'(d_ff) < cnt_ff))
      else $error("scan read an unoccupied slot");

   // The final response returns the sequencer to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_DONE && out_free) |=> (state_ff == SEQ_IDLE && rsp_valid_ff
                                             && rsp_data_ff.last))
      else $error("final response did not close the transaction");

   // Non-final responses only come from a list
   a_partial_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> (act_ff == ACT_LIST && state_ff != SEQ_IDLE))
      else $error("non-final response outside a list");

endmodule
